// File: src/nfa_pkg.sv
// nfa_pkg: shared types, constants and the find-first helper of the next-fit id allocator
package nfa_pkg;

    // fixed field widths
    localparam int ID_W           = 6;
    localparam int COUNT_W        = 7;
    localparam int CFG_W          = 7;
    localparam int MAP_W          = 64;
    localparam int DEF_POOL_DEPTH = 64;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register indexes
    localparam logic REG_POOL_SIZE = 1'b0;

    // reset value of the pool size register
    localparam logic [CFG_W-1:0] POOL_SIZE_RESET = CFG_W'(64);

    // request operation codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // controller states
    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed
    {
        logic load_req;
        logic exec;
    } ctrl_cmd_t;

    // lowest set bit of a map word: {found, index}
    function automatic logic [ID_W:0] find_first(input logic [MAP_W-1:0] vec);
        logic [ID_W:0] res;
        res = '0;
        for (int i = MAP_W - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                res = {1'b1, ID_W'(i)};
            end
        end
        return res;
    endfunction

endpackage

// File: src/nfa_req_if.sv
// nfa_req_if: request channel carrying the operation and the id to free
interface nfa_req_if import nfa_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            cmd;
    logic [ID_W-1:0] id;

    modport source (output valid, output cmd, output id, input ready);
    modport sink   (input valid, input cmd, input id, output ready);
endinterface

// File: src/nfa_rsp_if.sv
// nfa_rsp_if: response channel carrying the id, the ok flag and the count in use
interface nfa_rsp_if import nfa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    id_out;
    logic               ok;
    logic [COUNT_W-1:0] in_use;

    modport source (output valid, output id_out, output ok, output in_use, input ready);
    modport sink   (input valid, input id_out, input ok, input in_use, output ready);
endinterface

// File: src/nfa_ctrl.sv
// nfa_ctrl: state machine sequencing request capture, execution and response hand-off
module nfa_ctrl import nfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        in_fire;

    // state and response flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        in_fire        = 1'b0;

        // response word leaves when taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                in_fire  = in_valid;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // execute once the output register is free or freeing
                if (!out_valid_reg || out_ready)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // an accepted word is executed in the following state
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_EXEC))
        else $error("accepted word did not move controller to execute");

    // execution always produces a pending response
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid_reg)
        else $error("execution did not raise response valid");

    // a stalled response blocks execution of the next word
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && out_valid_reg && !out_ready) |-> !cmd.exec)
        else $error("response overwritten while stalled");

    // never take a new word while one is in execution
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> !in_ready)
        else $error("request accepted during execution");

endmodule

// File: src/nfa_datapath.sv
// nfa_datapath: used map, search pointer, count, next-fit search and response register
module nfa_datapath import nfa_pkg::*;
#(
    parameter int POOL_DEPTH = DEF_POOL_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    input  logic [CFG_W-1:0]   pool_size,
    input  logic               req_cmd,
    input  logic [ID_W-1:0]    req_id,
    output logic [ID_W-1:0]    id_out,
    output logic               ok,
    output logic [COUNT_W-1:0] in_use
);

    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(POOL_DEPTH);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAP_W);

    logic [POOL_DEPTH-1:0] used_map_reg;
    logic [POOL_DEPTH-1:0] used_map_next;
    logic [ID_W-1:0]       ptr_reg;
    logic [ID_W-1:0]       ptr_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;

    logic                  op_reg;
    logic [ID_W-1:0]       op_id_reg;
    logic [ID_W-1:0]       rsp_id_reg;
    logic [ID_W-1:0]       rsp_id_next;
    logic                  rsp_ok_reg;
    logic                  rsp_ok_next;
    logic [COUNT_W-1:0]    rsp_count_reg;

    logic [COUNT_W-1:0]    size;
    logic [MAP_W-1:0]      map64;
    logic [MAP_W-1:0]      map64_next;
    logic [MAP_W-1:0]      in_pool;
    logic [MAP_W-1:0]      upper;
    logic [MAP_W-1:0]      free_all;
    logic [MAP_W-1:0]      free_hi;
    logic [ID_W-1:0]       start;
    logic [ID_W:0]         hi_res;
    logic [ID_W:0]         all_res;
    logic [ID_W-1:0]       idx;
    logic [COUNT_W-1:0]    idx_inc;
    logic                  free_hit;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_map_reg <= '0;
            ptr_reg      <= '0;
            count_reg    <= '0;
        end
        else
        begin
            used_map_reg <= used_map_next;
            ptr_reg      <= ptr_next;
            count_reg    <= count_next;
        end
    end

    // request capture and response register
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg    <= req_cmd;
            op_id_reg <= req_id;
        end
        if (cmd.exec)
        begin
            rsp_id_reg    <= rsp_id_next;
            rsp_ok_reg    <= rsp_ok_next;
            rsp_count_reg <= count_next;
        end
    end

    // effective pool size, saturated to the depth, zero acting as one
    always_comb
    begin
        size = (pool_size > DEPTH_C) ? DEPTH_C : pool_size;
        if (size == '0)
        begin
            size = COUNT_W'(1);
        end
    end

    // rotating find-first over the free bits
    always_comb
    begin
        map64 = MAP_W'(used_map_reg);
        start = ({1'b0, ptr_reg} >= size) ? '0 : ptr_reg;
        for (int i = 0; i < MAP_W; i++)
        begin
            in_pool[i] = (COUNT_W'(i) < size);
            upper[i]   = (ID_W'(i) >= start);
        end
        free_all = ~map64 & in_pool;
        free_hi  = free_all & upper;
        hi_res   = find_first(free_hi);
        all_res  = find_first(free_all);
        idx      = hi_res[ID_W] ? hi_res[ID_W-1:0] : all_res[ID_W-1:0];
        idx_inc  = {1'b0, idx} + COUNT_W'(1);
        free_hit = ({1'b0, op_id_reg} < size) && map64[op_id_reg];
    end

    // state update on execution
    always_comb
    begin
        map64_next  = map64;
        ptr_next    = ptr_reg;
        count_next  = count_reg;
        rsp_id_next = '0;
        rsp_ok_next = 1'b0;
        if (op_reg == CMD_ALLOC)
        begin
            if (all_res[ID_W])
            begin
                map64_next[idx] = 1'b1;
                ptr_next        = (idx_inc >= size) ? '0 : idx_inc[ID_W-1:0];
                if (count_reg < COUNT_MAX)
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
                rsp_id_next = idx;
                rsp_ok_next = 1'b1;
            end
        end
        else
        begin
            rsp_id_next = op_id_reg;
            if (free_hit)
            begin
                map64_next[op_id_reg] = 1'b0;
                if (count_reg > '0)
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
                rsp_ok_next = 1'b1;
            end
        end
        if (!cmd.exec)
        begin
            map64_next = map64;
            ptr_next   = ptr_reg;
            count_next = count_reg;
        end
        used_map_next = map64_next[POOL_DEPTH-1:0];
    end

    assign id_out = rsp_id_reg;
    assign ok     = rsp_ok_reg;
    assign in_use = rsp_count_reg;

endmodule

// File: src/next_fit_id_allocator.sv
// next_fit_id_allocator: top level with configuration port, controller and datapath
//
// Usage
//   req channel: one word per operation, cmd 0 allocates an id, cmd 1 frees req.id.
//   rsp channel: one word per request with id_out, ok and in_use (count after the step).
//   APB port: register 0 at byte address 0 holds pool_size (7 bits, reset 64);
//   write it only while no request is outstanding. Addresses 4 to 7 read zero.
// Sequencing
//   a request is accepted in the idle state and executed in the execute state, where
//   the rotating find-first over the used map runs, once the response register is free
//   or being taken; the response word is registered on execution. No new request is
//   accepted while one is in execute, so requests are taken one at a time.
// Reset
//   rst_n clears the used map, search pointer and count and sets pool_size to 64.
// Stall
//   a waiting response word does not block acceptance of the next request; that
//   request waits in execute until the response register is taken.
module next_fit_id_allocator import nfa_pkg::*;
#(
    parameter int POOL_DEPTH = DEF_POOL_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    nfa_req_if.sink               req,
    nfa_rsp_if.source             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CFG_W-1:0] pool_size_reg;
    logic             reg_index;
    logic             cfg_write;
    ctrl_cmd_t        cmd;

    // register decode
    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;

    // pool size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= POOL_SIZE_RESET;
        end
        else if (cfg_write && (reg_index == REG_POOL_SIZE))
        begin
            pool_size_reg <= pwdata[CFG_W-1:0];
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_POOL_SIZE)
        begin
            prdata = APB_DATA_W'(pool_size_reg);
        end
    end

    // controller
    nfa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // datapath
    nfa_datapath #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .pool_size (pool_size_reg),
        .req_cmd   (req.cmd),
        .req_id    (req.id),
        .id_out    (rsp.id_out),
        .ok        (rsp.ok),
        .in_use    (rsp.in_use)
    );

endmodule

// File: sim/testbench.sv
// testbench: random and directed allocate/free words into the next-fit id allocator, all checked
module testbench;
    import nfa_pkg::*;

    // timing and run limits
    localparam int DEPTH          = DEF_POOL_DEPTH;
    localparam int GAP_PCT        = 26;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;
    localparam int QUEUE_AHEAD    = 4;
    localparam int PHASES         = 12;

    localparam logic [APB_ADDR_W-1:0] POOL_SIZE_ADDR = APB_ADDR_W'(4 * int'(REG_POOL_SIZE));
    localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR  = APB_ADDR_W'(4 * int'(REG_POOL_SIZE) + 4);

    typedef struct packed
    {
        logic            cmd;
        logic [ID_W-1:0] id;
    } request_word_t;

    typedef struct packed
    {
        logic [ID_W-1:0]    id_out;
        logic               ok;
        logic [COUNT_W-1:0] in_use;
    } alloc_result_t;

    // clock, reset and configuration port
    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    nfa_req_if req_ch ();
    nfa_rsp_if rsp_ch ();

    next_fit_id_allocator dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // words waiting to be offered and responses still owed
    request_word_t queued_reqs[$];
    alloc_result_t awaited[$];
    request_word_t next_req;
    alloc_result_t want;

    // shadow of the allocator state
    logic [MAP_W-1:0] used_bits  = '0;
    int               next_ptr   = 0;
    int               busy_count = 0;
    logic [CFG_W-1:0] pool_reg   = POOL_SIZE_RESET;

    // traffic shaping
    logic no_gaps    = 1'b0;
    int   hold_token = 0;
    int   hold_seen;
    int   hold_left;

    // tallies
    int fail_count   = 0;
    int quiet_cycles = 0;
    int sent_count   = 0;
    int granted      = 0;
    int refused      = 0;
    int released     = 0;
    int rejected     = 0;
    int settings     = 0;

    // phase plan for the random part
    int phase_pool[PHASES]  = '{64, 5, 127, 1, 64, 0, 33, 2, 100, 17, 64, 63};
    int phase_alloc[PHASES] = '{70, 60, 75, 50, 45, 50, 65, 55, 60, 60, 40, 70};
    int phase_len[PHASES]   = '{120, 80, 120, 60, 100, 40, 120, 60, 120, 100, 100, 105};

    initial
    begin
        forever #10 clk = ~clk;
    end

    // effective pool size: saturated to the depth, zero acts as one
    function automatic int pool_limit();
        int s;
        s = int'(pool_reg);
        if (s > DEPTH)
            s = DEPTH;
        if (s == 0)
            s = 1;
        return s;
    endfunction

    // next-fit search or release on the shadow state, queueing the response word
    function automatic void predict_step(input logic op, input logic [ID_W-1:0] sel);
        alloc_result_t w;
        int            size;
        int            start;
        int            idx;
        bit            found;
        size  = pool_limit();
        w     = '0;
        found = 1'b0;
        if (op == CMD_ALLOC)
        begin
            start = next_ptr;
            if (start >= size)
                start = 0;
            for (int k = 0; k < size; k++)
            begin
                idx = start + k;
                if (idx >= size)
                    idx -= size;
                if (!found && !used_bits[idx])
                begin
                    found          = 1'b1;
                    used_bits[idx] = 1'b1;
                    next_ptr       = (idx + 1 >= size) ? 0 : idx + 1;
                    if (busy_count < MAP_W)
                        busy_count++;
                    w.id_out = ID_W'(idx);
                    w.ok     = 1'b1;
                end
            end
            if (found)
                granted++;
            else
                refused++;
        end
        else
        begin
            w.id_out = sel;
            if (int'(sel) < size && used_bits[sel])
            begin
                used_bits[sel] = 1'b0;
                if (busy_count > 0)
                    busy_count--;
                w.ok = 1'b1;
                released++;
            end
            else
            begin
                rejected++;
            end
        end
        w.in_use = COUNT_W'(busy_count);
        awaited.push_back(w);
    endfunction

    // an id that is probably held, found by a scan from a random point in the pool
    function automatic logic [ID_W-1:0] pick_taken();
        int size;
        int base;
        int idx;
        size = pool_limit();
        base = $urandom_range(0, size - 1);
        for (int k = 0; k < size; k++)
        begin
            idx = (base + k) % size;
            if (used_bits[idx])
                return ID_W'(idx);
        end
        return ID_W'(base);
    endfunction

    // queue a request word, keeping only a few ahead of the driver
    task automatic offer(input logic op, input logic [ID_W-1:0] sel);
        request_word_t w;
        w.cmd = op;
        w.id  = sel;
        while (queued_reqs.size() >= QUEUE_AHEAD)
            @(negedge clk);
        queued_reqs.push_back(w);
    endtask

    // wait until every word has been taken and answered
    task automatic settle();
        do
            @(negedge clk);
        while (queued_reqs.size() != 0 || req_ch.valid || awaited.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // apb write: setup then access
    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == POOL_SIZE_ADDR)
            pool_reg = data[CFG_W-1:0];
        @(negedge clk);
    endtask

    // apb read, checked against the shadow register
    task automatic check_pool_reg();
        logic [APB_DATA_W-1:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= POOL_SIZE_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[CFG_W-1:0] !== pool_reg)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("pool_size read back: expected %0d, got %0d",
                         pool_reg, got[CFG_W-1:0]);
        end
        @(negedge clk);
    endtask

    task automatic set_pool(input int value);
        reg_write(POOL_SIZE_ADDR, APB_DATA_W'(value));
        check_pool_reg();
        settings++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.cmd   <= CMD_ALLOC;
            req_ch.id    <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (queued_reqs.size() != 0 && (no_gaps || $urandom_range(0, 99) >= GAP_PCT))
            begin
                next_req = queued_reqs.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.cmd   <= next_req.cmd;
                req_ch.id    <= next_req.id;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response sink with random stalls and one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_seen    <= 0;
        end
        else if (hold_token != hold_seen)
        begin
            hold_seen    <= hold_token;
            hold_left    <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PCT);
        end
    end

    // monitor: predict on each accepted request, compare each accepted response
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_step(req_ch.cmd, req_ch.id);
                sent_count++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected response word: id_out %0d ok %0d in_use %0d",
                                 rsp_ch.id_out, rsp_ch.ok, rsp_ch.in_use);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (rsp_ch.id_out !== want.id_out || rsp_ch.ok !== want.ok ||
                        rsp_ch.in_use !== want.in_use)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"response mismatch: expected id_out %0d ok %0d ",
                                      "in_use %0d, got id_out %0d ok %0d in_use %0d"},
                                     want.id_out, want.ok, want.in_use,
                                     rsp_ch.id_out, rsp_ch.ok, rsp_ch.in_use);
                    end
                end
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog on cycles without any accepted word
    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    // stimulus
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: unused frees, next-fit order, double free, ignored id on allocate
        check_pool_reg();
        offer(CMD_FREE, ID_W'(0));
        offer(CMD_FREE, ID_W'(63));
        offer(CMD_ALLOC, ID_W'(0));
        offer(CMD_ALLOC, ID_W'(0));
        offer(CMD_ALLOC, ID_W'(0));
        offer(CMD_FREE, ID_W'(1));
        offer(CMD_FREE, ID_W'(1));
        offer(CMD_ALLOC, ID_W'(0));
        offer(CMD_ALLOC, ID_W'(63));
        settle();

        // single-id pool: exhaustion and a held id above the pool
        set_pool(1);
        offer(CMD_ALLOC, ID_W'(0));
        offer(CMD_FREE, ID_W'(2));
        offer(CMD_FREE, ID_W'(0));
        offer(CMD_ALLOC, ID_W'(0));
        offer(CMD_ALLOC, ID_W'(0));
        settle();

        // zero acts as one
        set_pool(0);
        offer(CMD_ALLOC, ID_W'(0));
        offer(CMD_FREE, ID_W'(0));
        offer(CMD_ALLOC, ID_W'(0));
        settle();

        // oversized value saturates, then a write to an unmapped address
        set_pool(127);
        offer(CMD_ALLOC, ID_W'(0));
        offer(CMD_ALLOC, ID_W'(0));
        settle();
        reg_write(UNMAPPED_ADDR, APB_DATA_W'(5));
        check_pool_reg();
        offer(CMD_ALLOC, ID_W'(0));
        settle();

        // shrink below the pointer: search restarts at zero
        set_pool(3);
        offer(CMD_ALLOC, ID_W'(0));
        offer(CMD_ALLOC, ID_W'(0));
        offer(CMD_FREE, ID_W'(4));
        offer(CMD_FREE, ID_W'(63));
        settle();

        // random phases across pool sizes
        for (int p = 0; p < PHASES; p++)
        begin
            set_pool(phase_pool[p]);
            no_gaps = (p == 0);
            if (p == 2)
                hold_token++;
            for (int n = 0; n < phase_len[p]; n++)
            begin
                int r;
                r = $urandom_range(0, 99);
                if (r < phase_alloc[p])
                    offer(CMD_ALLOC, ID_W'($urandom_range(0, 63)));
                else if (r < 85)
                    offer(CMD_FREE, pick_taken());
                else
                    offer(CMD_FREE, ID_W'($urandom_range(0, 63)));
            end
            settle();
        end
        no_gaps = 1'b0;

        repeat (8) @(posedge clk);
        fail_count += awaited.size();

        $display("covered %0d request words over %0d pool settings", sent_count, settings);
        $display("ids granted %0d, refused %0d, released %0d, release rejected %0d",
                 granted, refused, released, rejected);
        $display("mismatches %0d", fail_count);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
src/nfa_pkg.sv
src/nfa_req_if.sv
src/nfa_rsp_if.sv
src/nfa_ctrl.sv
src/nfa_datapath.sv
src/next_fit_id_allocator.sv
sim/testbench.sv
